/* hw/rtl/bds_pkg.sv */
// ----------------------------------------------------------------------------
// bds_pkg: shared types and constants for the burner demand shaper
// Field widths, register map, reset values and action codes.
// ----------------------------------------------------------------------------
package bds_pkg;

	localparam int CENTI_W   = 14;
	localparam int REQ_W     = 16;
	localparam int TIME_W    = 32;
	localparam int ACTION_W  = 2;
	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [CENTI_W-1:0] FULL_SCALE_CENTI = 14'd10000;

	typedef logic [ACTION_W-1:0] action_t;

	localparam action_t ACT_SHAPE      = 2'd0;
	localparam action_t ACT_FORCE_STOP = 2'd1;
	localparam action_t ACT_BOOT_RESTORE = 2'd2;
	localparam action_t ACT_SOFT_RESET = 2'd3;

	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_FLOOR       = 3'd0;
	localparam reg_idx_t REG_LIGHT_MARGIN = 3'd1;
	localparam reg_idx_t REG_EXT_MARGIN  = 3'd2;
	localparam reg_idx_t REG_MIN_ON      = 3'd3;
	localparam reg_idx_t REG_MIN_OFF     = 3'd4;
	localparam reg_idx_t REG_MAX_RUNTIME = 3'd5;

	localparam logic [CENTI_W-1:0] RST_FLOOR        = 14'd3000;
	localparam logic [CENTI_W-1:0] RST_LIGHT_MARGIN = 14'd500;
	localparam logic [CENTI_W-1:0] RST_EXT_MARGIN   = 14'd500;
	localparam logic [TIME_W-1:0]  RST_MIN_ON       = 32'd180;
	localparam logic [TIME_W-1:0]  RST_MIN_OFF      = 32'd180;
	localparam logic [TIME_W-1:0]  RST_MAX_RUNTIME  = 32'd14400;

	// Seconds since 'since', or zero when the clock went backwards.
	function automatic logic [TIME_W-1:0] elapsed(
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] since
	);
		return (now >= since) ? (now - since) : '0;
	endfunction

endpackage

/* hw/rtl/burner_demand_shaper_top.sv */
// ----------------------------------------------------------------------------
// burner_demand_shaper_top: on/off burner demand shaper
// Hysteresis around a firing floor with minimum on / off timers, runtime
// trip and latched alarms; APB-style register port.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter on item_valid/item_ready with action, request_centi,
//    request_not_finite, now_s and min_off_already_served. Each request gives
//    exactly one result on result_valid/result_ready.
//  - Timing: the accepting edge loads the input register, and result_valid
//    rises at the edge where the shaping logic loads the result from it.
//  - Throughput: one request per cycle while no result waits; the state
//    update and the result for a request land at the same edge, so the
//    next request in the input register always sees the prior state.
//  - Stall: while a result waits, one more request is taken into the input
//    register; item_ready then drops until result_ready frees the result.
//  - Reset (arst_n low): registers return to their defaults (floor 30.00 %,
//    margins 5.00 %, 180 s on/off, 14400 s runtime), all burner state and
//    both alarm latches clear, both channels empty.
//  - Alarms clear only on arst_n; a soft reset action leaves them set.
//  - User must write registers only while no request is in flight; unchecked.
// ----------------------------------------------------------------------------
module burner_demand_shaper_top (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB-style register port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bds_pkg::ADDR_W-1:0]     paddr,
	input  logic [bds_pkg::DATA_W-1:0]     pwdata,
	output logic [bds_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	// request channel
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [bds_pkg::ACTION_W-1:0]   action,
	input  logic signed [bds_pkg::REQ_W-1:0] request_centi,
	input  logic                           request_not_finite,
	input  logic [bds_pkg::TIME_W-1:0]     now_s,
	input  logic                           min_off_already_served,
	// result channel
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [bds_pkg::CENTI_W-1:0]    demand_centi,
	output logic                           lit,
	output logic                           tripped,
	output logic                           input_alarm,
	output logic                           runtime_alarm
);
	import bds_pkg::*;

	// ---------------- configuration registers ----------------
	logic [CENTI_W-1:0] floor_q, light_margin_q, ext_margin_q;
	logic [TIME_W-1:0]  min_on_q, min_off_q, max_runtime_q;
	reg_idx_t           reg_idx;
	logic               reg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q        <= RST_FLOOR;
			light_margin_q <= RST_LIGHT_MARGIN;
			ext_margin_q   <= RST_EXT_MARGIN;
			min_on_q       <= RST_MIN_ON;
			min_off_q      <= RST_MIN_OFF;
			max_runtime_q  <= RST_MAX_RUNTIME;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_FLOOR:        floor_q        <= pwdata[CENTI_W-1:0];
				REG_LIGHT_MARGIN: light_margin_q <= pwdata[CENTI_W-1:0];
				REG_EXT_MARGIN:   ext_margin_q   <= pwdata[CENTI_W-1:0];
				REG_MIN_ON:       min_on_q       <= pwdata[TIME_W-1:0];
				REG_MIN_OFF:      min_off_q      <= pwdata[TIME_W-1:0];
				REG_MAX_RUNTIME:  max_runtime_q  <= pwdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_FLOOR:        prdata = DATA_W'(floor_q);
			REG_LIGHT_MARGIN: prdata = DATA_W'(light_margin_q);
			REG_EXT_MARGIN:   prdata = DATA_W'(ext_margin_q);
			REG_MIN_ON:       prdata = min_on_q;
			REG_MIN_OFF:      prdata = min_off_q;
			REG_MAX_RUNTIME:  prdata = max_runtime_q;
			default:          prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	logic                      valid_s1;
	action_t                   action_s1;
	logic signed [REQ_W-1:0]   req_s1;
	logic                      not_finite_s1;
	logic [TIME_W-1:0]         now_s1;
	logic                      waive_s1;
	logic                      advance;
	logic                      result_valid_q;

	// Request in stage 1 moves on whenever the result slot is free or freeing.
	assign advance    = valid_s1 & (~result_valid_q | result_ready);
	assign item_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			action_s1     <= action;
			req_s1        <= request_centi;
			not_finite_s1 <= request_not_finite;
			now_s1        <= now_s;
			waive_s1      <= min_off_already_served;
		end
	end

	// ---------------- burner state ----------------
	logic              burner_lit_q, trip_hold_q, off_anchored_q, off_waived_q;
	logic              input_alarm_q, runtime_alarm_q;
	logic [TIME_W-1:0] off_since_q, run_start_q;
	logic [CENTI_W-1:0] demand_q;

	logic              lit_n, trip_n, anch_n, waived_n, ia_n, ra_n;
	logic [TIME_W-1:0] off_since_n, run_start_n;
	logic [CENTI_W-1:0] demand_n;

	// request conditioning and thresholds
	logic                      req_bad;
	logic [CENTI_W-1:0]        req_clamp;
	logic [CENTI_W:0]          on_th;
	logic signed [CENTI_W+1:0] off_th;
	logic                      at_or_below_off, at_or_above_on;
	logic [TIME_W-1:0]         el_run, el_off;
	logic                      off_wait_done, go_dark, stays_lit;
	logic [CENTI_W-1:0]        floor_or_req;

	assign req_bad   = not_finite_s1 | req_s1[REQ_W-1];
	assign req_clamp = (req_s1[REQ_W-2:0] > (REQ_W-1)'(FULL_SCALE_CENTI))
		? FULL_SCALE_CENTI : req_s1[CENTI_W-1:0];
	assign on_th  = {1'b0, floor_q} + {1'b0, light_margin_q};
	assign off_th = $signed({2'b00, floor_q}) - $signed({2'b00, ext_margin_q});
	assign at_or_below_off = $signed({2'b00, req_clamp}) <= off_th;
	assign at_or_above_on  = {1'b0, req_clamp} >= on_th;

	assign el_run = elapsed(now_s1, run_start_q);
	// an unanchored off timer anchors at this now, so zero seconds have gone
	assign el_off = off_anchored_q ? elapsed(now_s1, off_since_q) : '0;
	assign off_wait_done = off_waived_q | (el_off >= min_off_q);

	// lit burner going dark on a comfort stop
	assign go_dark   = burner_lit_q & at_or_below_off & (el_run >= min_on_q);
	// only a burner that was already lit can overrun; a fresh light starts at 0
	assign stays_lit = burner_lit_q & ~go_dark;

	assign floor_or_req = (req_clamp < floor_q) ? floor_q : req_clamp;

	always_comb begin
		lit_n       = burner_lit_q;
		trip_n      = trip_hold_q;
		anch_n      = off_anchored_q;
		off_since_n = off_since_q;
		waived_n    = off_waived_q;
		run_start_n = run_start_q;
		ia_n        = input_alarm_q;
		ra_n        = runtime_alarm_q;
		demand_n    = '0;
		case (action_s1)
			ACT_SHAPE: begin
				if (!off_anchored_q) begin
					anch_n      = 1'b1;
					off_since_n = now_s1;
				end
				if (req_bad) begin
					ia_n = 1'b1;
					if (burner_lit_q) begin
						lit_n       = 1'b0;
						anch_n      = 1'b1;
						off_since_n = now_s1;
						waived_n    = 1'b0;
					end
				end else if (trip_hold_q) begin
					if (at_or_below_off) trip_n = 1'b0;
				end else if (stays_lit && (el_run > max_runtime_q)) begin
					trip_n      = 1'b1;
					ra_n        = 1'b1;
					lit_n       = 1'b0;
					anch_n      = 1'b1;
					off_since_n = now_s1;
					waived_n    = 1'b0;
				end else if (stays_lit) begin
					demand_n = (floor_or_req > FULL_SCALE_CENTI)
						? FULL_SCALE_CENTI : floor_or_req;
				end else if (go_dark) begin
					lit_n       = 1'b0;
					anch_n      = 1'b1;
					off_since_n = now_s1;
					waived_n    = 1'b0;
				end else if (at_or_above_on && off_wait_done) begin
					lit_n       = 1'b1;
					waived_n    = 1'b0;
					run_start_n = now_s1;
					demand_n    = (floor_or_req > FULL_SCALE_CENTI)
						? FULL_SCALE_CENTI : floor_or_req;
				end
			end
			ACT_FORCE_STOP: begin
				lit_n       = 1'b0;
				anch_n      = 1'b1;
				off_since_n = now_s1;
				waived_n    = 1'b0;
			end
			ACT_BOOT_RESTORE: begin
				lit_n       = 1'b0;
				trip_n      = 1'b0;
				anch_n      = 1'b1;
				off_since_n = now_s1;
				waived_n    = waive_s1;
			end
			default: begin
				lit_n    = 1'b0;
				trip_n   = 1'b0;
				anch_n   = 1'b0;
				waived_n = 1'b0;
			end
		endcase
	end

	// State and result update at the same edge; flags are read straight from
	// the state, which only moves when a new result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burner_lit_q    <= 1'b0;
			trip_hold_q     <= 1'b0;
			off_anchored_q  <= 1'b0;
			off_since_q     <= '0;
			off_waived_q    <= 1'b0;
			run_start_q     <= '0;
			input_alarm_q   <= 1'b0;
			runtime_alarm_q <= 1'b0;
			result_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				burner_lit_q    <= lit_n;
				trip_hold_q     <= trip_n;
				off_anchored_q  <= anch_n;
				off_since_q     <= off_since_n;
				off_waived_q    <= waived_n;
				run_start_q     <= run_start_n;
				input_alarm_q   <= ia_n;
				runtime_alarm_q <= ra_n;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			demand_q <= demand_n;
		end
	end

	assign result_valid  = result_valid_q;
	assign demand_centi  = demand_q;
	assign lit           = burner_lit_q;
	assign tripped       = trip_hold_q;
	assign input_alarm   = input_alarm_q;
	assign runtime_alarm = runtime_alarm_q;

`ifndef NO_ASSERTIONS
	// a held-off burner is never lit
	a_lit_not_tripped: assert property (@(posedge clk) disable iff (!arst_n)
		!(burner_lit_q && trip_hold_q))
		else $error("burner lit while trip hold active");

	// a trip hold only exists after the runtime alarm latched
	a_trip_has_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		trip_hold_q |-> runtime_alarm_q)
		else $error("trip hold without runtime alarm");

	// nonzero demand only while lit
	a_demand_needs_lit: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && demand_q != '0) |-> burner_lit_q)
		else $error("nonzero demand with burner dark");

	// alarms only clear on reset
	a_alarms_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(input_alarm_q || runtime_alarm_q) |=>
		(input_alarm_q || !$past(input_alarm_q)) &&
		(runtime_alarm_q || !$past(runtime_alarm_q)))
		else $error("latched alarm cleared without reset");
`endif

endmodule

/* sim/burner_demand_shaper_top_tb.sv */
// ----------------------------------------------------------------------------
// burner_demand_shaper_top_tb: self-checking bench for the burner shaper
// Streams shape / stop / restore / soft-reset requests with random idling on
// both channels. An in-bench copy of the shaper state predicts every result,
// and each result is compared field by field in arrival order. Register
// settings change between request bursts only while nothing is in flight.
// ----------------------------------------------------------------------------
module burner_demand_shaper_top_tb;

	import bds_pkg::*;

	// one request as it goes onto the port
	typedef struct {
		action_t                   act;
		logic signed [REQ_W-1:0]   level;
		logic                      not_finite;
		logic [TIME_W-1:0]         now;
		logic                      skip_off_wait;
	} burner_req_t;

	// one result as it comes back
	typedef struct {
		logic [CENTI_W-1:0] demand;
		logic               lit;
		logic               tripped;
		logic               in_alarm;
		logic               rt_alarm;
	} burner_res_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;

	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [ADDR_W-1:0]         paddr = '0;
	logic [DATA_W-1:0]         pwdata = '0;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	logic                      item_valid = 1'b0;
	logic                      item_ready;
	logic [ACTION_W-1:0]       action = ACT_SHAPE;
	logic signed [REQ_W-1:0]   request_centi = '0;
	logic                      request_not_finite = 1'b0;
	logic [TIME_W-1:0]         now_s = '0;
	logic                      min_off_already_served = 1'b0;

	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic [CENTI_W-1:0]        demand_centi;
	logic                      lit;
	logic                      tripped;
	logic                      input_alarm;
	logic                      runtime_alarm;

	burner_demand_shaper_top uut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.psel                   (psel),
		.penable                (penable),
		.pwrite                 (pwrite),
		.paddr                  (paddr),
		.pwdata                 (pwdata),
		.prdata                 (prdata),
		.pready                 (pready),
		.item_valid             (item_valid),
		.item_ready             (item_ready),
		.action                 (action),
		.request_centi          (request_centi),
		.request_not_finite     (request_not_finite),
		.now_s                  (now_s),
		.min_off_already_served (min_off_already_served),
		.result_valid           (result_valid),
		.result_ready           (result_ready),
		.demand_centi           (demand_centi),
		.lit                    (lit),
		.tripped                (tripped),
		.input_alarm            (input_alarm),
		.runtime_alarm          (runtime_alarm)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run (~1.5k requests, each with
	// idle bursts on either side plus pipeline latency).
	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Shaper prediction. Register copies start at the reset defaults; burner
	// state starts cleared, matching the single reset at time zero.
	// ------------------------------------------------------------------------
	logic [CENTI_W-1:0] cfg_floor        = RST_FLOOR;
	logic [CENTI_W-1:0] cfg_light_margin = RST_LIGHT_MARGIN;
	logic [CENTI_W-1:0] cfg_ext_margin   = RST_EXT_MARGIN;
	logic [TIME_W-1:0]  cfg_min_on       = RST_MIN_ON;
	logic [TIME_W-1:0]  cfg_min_off      = RST_MIN_OFF;
	logic [TIME_W-1:0]  cfg_max_run      = RST_MAX_RUNTIME;

	logic               flame_on       = 1'b0;
	logic               trip_held      = 1'b0;
	logic               off_anchor_set = 1'b0;
	logic [TIME_W-1:0]  off_start_s    = '0;
	logic               off_wait_skip  = 1'b0;
	logic [TIME_W-1:0]  run_start_s    = '0;
	logic               bad_input_seen = 1'b0;
	logic               overrun_seen   = 1'b0;

	// seconds since 'since'; a clock that stepped backwards counts as zero
	function automatic logic [TIME_W-1:0] secs_since(logic [TIME_W-1:0] t,
			logic [TIME_W-1:0] since);
		return (t >= since) ? t - since : '0;
	endfunction

	// burner goes out: off timer restarts at t, any boot waiver is used up
	function automatic void extinguish(logic [TIME_W-1:0] t);
		flame_on       = 1'b0;
		off_anchor_set = 1'b1;
		off_start_s    = t;
		off_wait_skip  = 1'b0;
	endfunction

	function automatic burner_res_t predict_result(burner_req_t r);
		burner_res_t e;
		int          lvl;
		int          on_th;
		int          off_th;
		int          out_lvl;
		e.demand = '0;
		case (r.act)
			ACT_SHAPE: begin
				// first shape after power-up or soft reset anchors the off timer
				if (!off_anchor_set) begin
					off_anchor_set = 1'b1;
					off_start_s    = r.now;
				end
				if (r.not_finite || r.level < 0) begin
					// bad request: latch alarm, put out the flame, keep any trip hold
					bad_input_seen = 1'b1;
					if (flame_on)
						extinguish(r.now);
				end else begin
					lvl = int'(r.level);
					if (lvl > int'(FULL_SCALE_CENTI))
						lvl = int'(FULL_SCALE_CENTI);
					on_th  = int'(cfg_floor) + int'(cfg_light_margin);
					off_th = int'(cfg_floor) - int'(cfg_ext_margin);
					if (trip_held) begin
						// held dark until demand falls to the off threshold
						if (lvl <= off_th)
							trip_held = 1'b0;
					end else begin
						if (flame_on) begin
							if (lvl <= off_th && secs_since(r.now, run_start_s) >= cfg_min_on)
								extinguish(r.now);
						end else if (lvl >= on_th &&
								(off_wait_skip || secs_since(r.now, off_start_s) >= cfg_min_off)) begin
							flame_on      = 1'b1;
							off_wait_skip = 1'b0;
							run_start_s   = r.now;
						end
						if (flame_on && secs_since(r.now, run_start_s) > cfg_max_run) begin
							trip_held    = 1'b1;
							overrun_seen = 1'b1;
							extinguish(r.now);
						end else if (flame_on) begin
							// fire at least at the floor, never beyond full scale
							out_lvl = (lvl < int'(cfg_floor)) ? int'(cfg_floor) : lvl;
							if (out_lvl > int'(FULL_SCALE_CENTI))
								out_lvl = int'(FULL_SCALE_CENTI);
							e.demand = out_lvl[CENTI_W-1:0];
						end
					end
				end
			end
			ACT_FORCE_STOP: begin
				extinguish(r.now);
			end
			ACT_BOOT_RESTORE: begin
				flame_on       = 1'b0;
				trip_held      = 1'b0;
				off_anchor_set = 1'b1;
				off_start_s    = r.now;
				off_wait_skip  = r.skip_off_wait;
			end
			default: begin
				// soft reset: state clears, latched alarms survive
				flame_on       = 1'b0;
				trip_held      = 1'b0;
				off_anchor_set = 1'b0;
				off_wait_skip  = 1'b0;
			end
		endcase
		e.lit      = flame_on;
		e.tripped  = trip_held;
		e.in_alarm = bad_input_seen;
		e.rt_alarm = overrun_seen;
		return e;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus bookkeeping
	// ------------------------------------------------------------------------
	burner_req_t       pending_requests[$];
	burner_res_t       expected_results[$];
	burner_req_t       on_port;
	burner_res_t       want;
	int                gap_left = 0;
	int                stall_left = 0;
	logic              calm = 1'b0;      // no idling on either side when set
	int unsigned       fail_count = 0;

	// burner clock used by the random requests, plus step sizes per setting
	logic [TIME_W-1:0] clock_s = '0;
	logic [TIME_W-1:0] t_short = 200;
	logic [TIME_W-1:0] t_long  = 14400;

	function automatic void queue_req(action_t a, int lvl, logic nf,
			logic [TIME_W-1:0] t, logic skip);
		burner_req_t r;
		r.act           = a;
		r.level         = REQ_W'(lvl);
		r.not_finite    = nf;
		r.now           = t;
		r.skip_off_wait = skip;
		pending_requests.push_back(r);
	endfunction

	// Random request: mostly shape actions on a clock that moves forward,
	// with levels clustered on the light / extinguish thresholds so the
	// hysteresis and timer paths get exercised; some long jumps reach the
	// runtime trip, and a few backward steps and bad levels are mixed in.
	function automatic burner_req_t random_request();
		burner_req_t r;
		int          pick;
		int          lvl;
		int          base;
		pick = $urandom_range(0, 99);
		r.act = (pick < 85) ? ACT_SHAPE :
			(pick < 90) ? ACT_FORCE_STOP :
			(pick < 95) ? ACT_BOOT_RESTORE : ACT_SOFT_RESET;

		pick = $urandom_range(0, 99);
		if (pick < 50)
			clock_s = clock_s + $urandom_range(0, t_short);
		else if (pick < 88)
			clock_s = clock_s + $urandom_range(t_short / 2, t_short * 2);
		else if (pick < 96)
			clock_s = clock_s + t_long - 3 + $urandom_range(0, 6);
		else
			clock_s = clock_s - $urandom_range(1, t_short + 1);
		r.now = clock_s;

		pick = $urandom_range(0, 99);
		r.not_finite = 1'b0;
		if (pick < 45) begin
			base = $urandom_range(0, 1) ?
				int'(cfg_floor) + int'(cfg_light_margin) :
				int'(cfg_floor) - int'(cfg_ext_margin);
			lvl = base + int'($urandom_range(0, 8)) - 4;
			if (lvl > 32767)
				lvl = 32767;
		end else if (pick < 80) begin
			lvl = $urandom_range(0, 10000);
		end else if (pick < 88) begin
			lvl = $urandom_range(10001, 32767);
		end else if (pick < 95) begin
			lvl = -int'($urandom_range(1, 32768));
		end else begin
			lvl = $urandom_range(0, 65535);
			r.not_finite = 1'b1;
		end
		if ($urandom_range(0, 49) == 0)
			r.not_finite = 1'b1;
		r.level = REQ_W'(lvl);
		r.skip_off_wait = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic void queue_random(int n, logic [TIME_W-1:0] step_short,
			logic [TIME_W-1:0] step_long);
		t_short = step_short;
		t_long  = step_long;
		clock_s = $urandom();
		repeat (n)
			pending_requests.push_back(random_request());
	endfunction

	// Block until every queued request has been taken and answered, then let
	// the input and result registers of the pipeline settle.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_requests.size() != 0 || item_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle; the register takes the value
	// at the edge where psel and penable are both high.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FLOOR:        cfg_floor        = val[CENTI_W-1:0];
			REG_LIGHT_MARGIN: cfg_light_margin = val[CENTI_W-1:0];
			REG_EXT_MARGIN:   cfg_ext_margin   = val[CENTI_W-1:0];
			REG_MIN_ON:       cfg_min_on       = val;
			REG_MIN_OFF:      cfg_min_off      = val;
			REG_MAX_RUNTIME:  cfg_max_run      = val;
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [CENTI_W-1:0] fl, logic [CENTI_W-1:0] lm,
			logic [CENTI_W-1:0] em, logic [TIME_W-1:0] on_s, logic [TIME_W-1:0] off_s,
			logic [TIME_W-1:0] run_s);
		wait_drained();
		write_reg(REG_FLOOR, DATA_W'(fl));
		write_reg(REG_LIGHT_MARGIN, DATA_W'(lm));
		write_reg(REG_EXT_MARGIN, DATA_W'(em));
		write_reg(REG_MIN_ON, on_s);
		write_reg(REG_MIN_OFF, off_s);
		write_reg(REG_MAX_RUNTIME, run_s);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk through the shaper at reset settings (floor 30 %,
		// margins 5 %, 180 s on/off, 4 h runtime).
		queue_req(ACT_SHAPE, 0, 1'b0, 100, 1'b0);            // anchors off timer
		queue_req(ACT_SHAPE, 3500, 1'b0, 200, 1'b0);         // off wait not served
		queue_req(ACT_SHAPE, 3500, 1'b0, 280, 1'b0);         // lights
		queue_req(ACT_SHAPE, 32767, 1'b0, 300, 1'b0);        // clamp to full scale
		queue_req(ACT_SHAPE, 2000, 1'b0, 350, 1'b0);         // under floor, min on holds
		queue_req(ACT_SHAPE, 2500, 1'b0, 460, 1'b0);         // extinguish
		queue_req(ACT_SHAPE, 3500, 1'b0, 500, 1'b0);         // off wait again
		queue_req(ACT_BOOT_RESTORE, 0, 1'b0, 510, 1'b1);     // waive off wait
		queue_req(ACT_SHAPE, 3500, 1'b0, 511, 1'b0);         // lights on waiver
		queue_req(ACT_SHAPE, 5000, 1'b0, 14912, 1'b0);       // runtime trip
		queue_req(ACT_SHAPE, 5000, 1'b0, 15000, 1'b0);       // held dark
		queue_req(ACT_SHAPE, -1, 1'b0, 15050, 1'b0);         // bad level while tripped
		queue_req(ACT_SHAPE, 2500, 1'b0, 15100, 1'b0);       // trip hold releases
		queue_req(ACT_SHAPE, 3500, 1'b0, 15400, 1'b0);       // relight
		queue_req(ACT_SHAPE, 5000, 1'b1, 15450, 1'b0);       // not finite while lit
		queue_req(ACT_SHAPE, -32768, 1'b0, 15500, 1'b0);     // most negative level
		queue_req(ACT_FORCE_STOP, 0, 1'b0, 15600, 1'b0);     // stop while already off
		queue_req(ACT_SHAPE, 3500, 1'b0, 100, 1'b0);         // clock went backwards
		queue_req(ACT_SOFT_RESET, 0, 1'b0, 200, 1'b0);
		queue_req(ACT_SHAPE, 3500, 1'b0, 0, 1'b0);           // re-anchors at zero
		queue_req(ACT_BOOT_RESTORE, 0, 1'b0, 32'hFFFF_FF00, 1'b0);
		queue_req(ACT_SHAPE, 3500, 1'b0, 32'hFFFF_FFFF, 1'b0); // lights at max time
		queue_req(ACT_FORCE_STOP, 32'h0000_7FFF, 1'b1, 32'hFFFF_FFFF, 1'b1);
		queue_req(ACT_SHAPE, 32'h0000_5555, 1'b0, 32'hAAAA_AAAA, 1'b1);
		queue_random(200, 200, 14400);

		// everything at zero: any lit second overruns the runtime
		apply_settings(0, 0, 0, 0, 0, 0);
		queue_random(240, 5, 2);

		// top of range: off threshold at zero, timers never served
		apply_settings(10000, 0, 10000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_random(240, 1000, 32'h8000_0000);

		// floor above full scale: demand saturates
		apply_settings(14'h3FFF, 0, 14'h3FFF, 10, 10, 500);
		queue_random(240, 30, 500);

		// extinguish margin beyond the floor: negative off threshold
		apply_settings(300, 200, 1000, 60, 40, 2000);
		queue_random(240, 60, 2000);

		// closing stretch with both sides always ready
		apply_settings(4500, 250, 750, 100, 150, 3000);
		calm = 1'b1;
		queue_random(240, 150, 3000);

		wait_drained();
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Request driver: presents the next pending request whenever the port is
	// free, holding it until taken. The result is predicted at acceptance,
	// so predictions run in the same order the block processes requests.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready)
				expected_results.push_back(predict_result(on_port));
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (pending_requests.size() != 0) begin
					on_port = pending_requests.pop_front();
					action                 <= on_port.act;
					request_centi          <= on_port.level;
					request_not_finite     <= on_port.not_finite;
					now_s                  <= on_port.now;
					min_off_already_served <= on_port.skip_off_wait;
					item_valid             <= 1'b1;
					// idle burst after this request
					if (!calm && $urandom_range(0, 7) == 0)
						gap_left = $urandom_range(1, 5);
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Result back-pressure in random bursts.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 4);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Result monitor: compare against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding: demand_centi %0d", demand_centi);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (demand_centi !== want.demand) begin
					$error("demand_centi: expected %0d, got %0d", want.demand, demand_centi);
					fail_count++;
				end
				if (lit !== want.lit) begin
					$error("lit: expected %0b, got %0b", want.lit, lit);
					fail_count++;
				end
				if (tripped !== want.tripped) begin
					$error("tripped: expected %0b, got %0b", want.tripped, tripped);
					fail_count++;
				end
				if (input_alarm !== want.in_alarm) begin
					$error("input_alarm: expected %0b, got %0b", want.in_alarm, input_alarm);
					fail_count++;
				end
				if (runtime_alarm !== want.rt_alarm) begin
					$error("runtime_alarm: expected %0b, got %0b", want.rt_alarm, runtime_alarm);
					fail_count++;
				end
			end
		end
	end

endmodule

/* burner_demand_shaper_top.f */
hw/rtl/bds_pkg.sv
hw/rtl/burner_demand_shaper_top.sv
sim/burner_demand_shaper_top_tb.sv
